// ===== hw/rtl/cartridge_bank_mapper_rtc_unit_defines.svh =====
// Assertion macros used by the checker of the cartridge bank mapper unit.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef CARTRIDGE_BANK_MAPPER_RTC_UNIT_DEFINES_SVH
`define CARTRIDGE_BANK_MAPPER_RTC_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CBMR_ASSERT_IMP(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define CBMR_ASSERT_NXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== hw/rtl/cbmr_pkg.sv =====
// Package for the cartridge bank mapper unit: field widths, codes and decode constants.
// Used by the channel interfaces, the top level and its checker; depends on nothing.
package cbmr_pkg;

	localparam int OPCODE_W  = 2;
	localparam int ADDRESS_W = 16;
	localparam int DATA_W    = 8;
	localparam int TARGET_W  = 3;
	localparam int MEM_ADDR_W = 22;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 1;

	typedef logic [OPCODE_W-1:0]   opcode_t;
	typedef logic [ADDRESS_W-1:0]  address_t;
	typedef logic [DATA_W-1:0]     byte_t;
	typedef logic [TARGET_W-1:0]   target_t;
	typedef logic [MEM_ADDR_W-1:0] mem_addr_t;

	localparam opcode_t OP_READ  = 2'd0;
	localparam opcode_t OP_WRITE = 2'd1;
	localparam opcode_t OP_TICK  = 2'd2;

	localparam target_t TGT_DATA   = 3'd0;
	localparam target_t TGT_ROM    = 3'd1;
	localparam target_t TGT_RAM_RD = 3'd2;
	localparam target_t TGT_RAM_WR = 3'd3;
	localparam target_t TGT_NONE   = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_WIDE_MODE   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RAM_PRESENT = 1'd1;

	// Bus regions by address bits 15:13.
	localparam logic [2:0] RGN_RAM_EN   = 3'b000;
	localparam logic [2:0] RGN_ROM_BANK = 3'b001;
	localparam logic [2:0] RGN_RAM_SEL  = 3'b010;
	localparam logic [2:0] RGN_LATCH    = 3'b011;
	localparam logic [2:0] RGN_EXT_RAM  = 3'b101;

	localparam byte_t RAM_LIMIT_NARROW = 8'h03;
	localparam byte_t RAM_LIMIT_WIDE   = 8'h07;
	localparam byte_t SEL_SECONDS = 8'h08;
	localparam byte_t SEL_MINUTES = 8'h09;
	localparam byte_t SEL_HOURS   = 8'h0a;
	localparam byte_t SEL_DAY_LO  = 8'h0b;
	localparam byte_t SEL_DAY_HI  = 8'h0c;

	localparam logic [3:0] RAM_EN_KEY = 4'ha;
	localparam byte_t OPEN_BYTE = 8'hff;
	localparam byte_t SEC_MIN_LIMIT = 8'd60;
	localparam byte_t HOUR_LIMIT    = 8'd24;
	localparam logic [5:0] SEC_MIN_LAST = 6'd59;
	localparam logic [4:0] HOUR_LAST    = 5'd23;

endpackage

// ===== hw/rtl/cbmr_channels.sv =====
// Valid/ready channel interfaces for bus accesses in and decoded results out.
// Depends on cbmr_pkg for the field types.
interface cbmr_access_if;
	import cbmr_pkg::*;
	logic     valid;
	logic     ready;
	opcode_t  opcode;
	address_t address;
	byte_t    bus_data;
	modport source (output valid, output opcode, output address, output bus_data, input ready);
	modport sink (input valid, input opcode, input address, input bus_data, output ready);
endinterface

interface cbmr_result_if;
	import cbmr_pkg::*;
	logic      valid;
	logic      ready;
	target_t   target;
	mem_addr_t mem_address;
	byte_t     read_data;
	byte_t     write_data;
	modport source (output valid, output target, output mem_address, output read_data,
		output write_data, input ready);
	modport sink (input valid, input target, input mem_address, input read_data,
		input write_data, output ready);
endinterface

// ===== hw/rtl/cartridge_bank_mapper_rtc_unit.sv =====
// Top level of the cartridge bank mapper with real-time clock.
// Depends on cbmr_pkg and the channel interfaces in cbmr_channels.sv.
//
// Each accepted bus read, bus write or one-second tick yields exactly one result. An access
// is captured in an input register, decoded against the mapper and clock registers, and
// lands in a result register, from which it is offered. A new access can be taken in every
// cycle while results are taken. The result register holds while the sink stalls; the input
// register then fills and access ready drops. Configuration writes take effect on the edge
// they are presented and belong to idle periods.
module cartridge_bank_mapper_rtc_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	cbmr_access_if.sink                       access,
	cbmr_result_if.source                     result,
	input  logic                              cfg_wr_en,
	input  logic [cbmr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [cbmr_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
	import cbmr_pkg::*;

	logic        wide_mode_q, ram_present_q;
	logic [7:0]  rom_bank_q, rom_bank_d;
	logic        ram_enable_q, ram_enable_d;
	byte_t       ram_select_q, ram_select_d;
	logic [5:0]  seconds_q, seconds_d;
	logic [5:0]  minutes_q, minutes_d;
	logic [4:0]  hours_q, hours_d;
	logic [8:0]  days_q, days_d;
	logic        halted_q, halted_d;
	logic        day_overflow_q, day_overflow_d;
	logic        latch_last_q, latch_last_d;
	logic [25:0] latched_time_q, latched_time_d;
	logic [1:0]  latched_flags_q, latched_flags_d;

	logic        valid_s1;
	opcode_t     opcode_s1;
	address_t    address_s1;
	byte_t       bus_data_s1;

	logic        valid_s2;
	target_t     target_s2;
	mem_addr_t   mem_address_s2;
	byte_t       read_data_s2;
	byte_t       write_data_s2;

	logic        advance;
	logic        ram_bank_hit;
	byte_t       rom_bank_sel;
	target_t     tgt;
	mem_addr_t   maddr;
	byte_t       rdata;
	byte_t       wdata;

	assign advance      = valid_s1 && (!valid_s2 || result.ready);
	assign access.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wide_mode_q   <= 1'b0;
			ram_present_q <= 1'b1;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_WIDE_MODE:   wide_mode_q   <= cfg_wdata[0];
				CFG_RAM_PRESENT: ram_present_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (access.ready) begin
			valid_s1 <= access.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (access.valid && access.ready) begin
			opcode_s1   <= access.opcode;
			address_s1  <= access.address;
			bus_data_s1 <= access.bus_data;
		end
	end

	always_comb begin
		ram_bank_hit = ram_select_q <= (wide_mode_q ? RAM_LIMIT_WIDE : RAM_LIMIT_NARROW);
		rom_bank_sel = wide_mode_q ? bus_data_s1 : {1'b0, bus_data_s1[6:0]};

		tgt   = TGT_NONE;
		maddr = '0;
		rdata = '0;
		wdata = '0;

		rom_bank_d      = rom_bank_q;
		ram_enable_d    = ram_enable_q;
		ram_select_d    = ram_select_q;
		seconds_d       = seconds_q;
		minutes_d       = minutes_q;
		hours_d         = hours_q;
		days_d          = days_q;
		halted_d        = halted_q;
		day_overflow_d  = day_overflow_q;
		latch_last_d    = latch_last_q;
		latched_time_d  = latched_time_q;
		latched_flags_d = latched_flags_q;

		case (opcode_s1)
			OP_READ: begin
				case (address_s1[15:13]) inside
					RGN_RAM_EN, RGN_ROM_BANK: begin
						tgt   = TGT_ROM;
						maddr = {6'd0, address_s1};
					end
					RGN_RAM_SEL, RGN_LATCH: begin
						tgt   = TGT_ROM;
						maddr = {rom_bank_q, address_s1[13:0]};
					end
					RGN_EXT_RAM: begin
						tgt   = TGT_DATA;
						rdata = OPEN_BYTE;
						if (ram_enable_q) begin
							if (ram_bank_hit) begin
								if (ram_present_q) begin
									tgt   = TGT_RAM_RD;
									rdata = '0;
									maddr = {6'd0, ram_select_q[2:0], address_s1[12:0]};
								end
							end else begin
								case (ram_select_q)
									SEL_SECONDS: rdata = {2'd0, latched_time_q[5:0]};
									SEL_MINUTES: rdata = {2'd0, latched_time_q[11:6]};
									SEL_HOURS:   rdata = {3'd0, latched_time_q[16:12]};
									SEL_DAY_LO:  rdata = latched_time_q[24:17];
									SEL_DAY_HI:  rdata = {latched_flags_q[1], latched_flags_q[0],
										5'd0, latched_time_q[25]};
									default:     rdata = OPEN_BYTE;
								endcase
							end
						end
					end
					default: begin
						tgt   = TGT_DATA;
						rdata = bus_data_s1;
					end
				endcase
			end
			OP_WRITE: begin
				case (address_s1[15:13])
					RGN_RAM_EN: ram_enable_d = bus_data_s1[3:0] == RAM_EN_KEY;
					RGN_ROM_BANK: rom_bank_d = (rom_bank_sel == 8'd0) ? 8'd1 : rom_bank_sel;
					RGN_RAM_SEL: ram_select_d = bus_data_s1;
					RGN_LATCH: begin
						if (!latch_last_q && bus_data_s1 == 8'd1) begin
							latched_time_d  = {days_q, hours_q, minutes_q, seconds_q};
							latched_flags_d = {day_overflow_q, halted_q};
						end
						latch_last_d = bus_data_s1[0];
					end
					RGN_EXT_RAM: begin
						if (ram_enable_q) begin
							if (ram_bank_hit) begin
								if (ram_present_q) begin
									tgt   = TGT_RAM_WR;
									maddr = {6'd0, ram_select_q[2:0], address_s1[12:0]};
									wdata = bus_data_s1;
								end
							end else begin
								case (ram_select_q)
									SEL_SECONDS: seconds_d = (bus_data_s1 >= SEC_MIN_LIMIT) ?
										6'd0 : bus_data_s1[5:0];
									SEL_MINUTES: minutes_d = (bus_data_s1 >= SEC_MIN_LIMIT) ?
										6'd0 : bus_data_s1[5:0];
									SEL_HOURS:   hours_d = (bus_data_s1 >= HOUR_LIMIT) ?
										5'd0 : bus_data_s1[4:0];
									SEL_DAY_LO:  days_d = {days_q[8], bus_data_s1};
									SEL_DAY_HI: begin
										days_d         = {bus_data_s1[0], days_q[7:0]};
										halted_d       = bus_data_s1[6];
										day_overflow_d = bus_data_s1[7];
									end
									default: ;
								endcase
							end
						end
					end
					default: ;
				endcase
			end
			OP_TICK: begin
				if (!halted_q) begin
					if (seconds_q != SEC_MIN_LAST) begin
						seconds_d = seconds_q + 6'd1;
					end else begin
						seconds_d = '0;
						if (minutes_q != SEC_MIN_LAST) begin
							minutes_d = minutes_q + 6'd1;
						end else begin
							minutes_d = '0;
							if (hours_q != HOUR_LAST) begin
								hours_d = hours_q + 5'd1;
							end else begin
								hours_d = '0;
								days_d  = days_q + 9'd1;
								if (days_q == 9'h1ff) begin
									day_overflow_d = 1'b1;
								end
							end
						end
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_bank_q      <= 8'd1;
			ram_enable_q    <= 1'b0;
			ram_select_q    <= '0;
			seconds_q       <= '0;
			minutes_q       <= '0;
			hours_q         <= '0;
			days_q          <= '0;
			halted_q        <= 1'b0;
			day_overflow_q  <= 1'b0;
			latch_last_q    <= 1'b0;
			latched_time_q  <= '0;
			latched_flags_q <= '0;
		end else if (advance) begin
			rom_bank_q      <= rom_bank_d;
			ram_enable_q    <= ram_enable_d;
			ram_select_q    <= ram_select_d;
			seconds_q       <= seconds_d;
			minutes_q       <= minutes_d;
			hours_q         <= hours_d;
			days_q          <= days_d;
			halted_q        <= halted_d;
			day_overflow_q  <= day_overflow_d;
			latch_last_q    <= latch_last_d;
			latched_time_q  <= latched_time_d;
			latched_flags_q <= latched_flags_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || result.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			target_s2      <= tgt;
			mem_address_s2 <= maddr;
			read_data_s2   <= rdata;
			write_data_s2  <= wdata;
		end
	end

	assign result.valid       = valid_s2;
	assign result.target      = target_s2;
	assign result.mem_address = mem_address_s2;
	assign result.read_data   = read_data_s2;
	assign result.write_data  = write_data_s2;

endmodule

// ===== hw/rtl/cbmr_checker.sv =====
// Port-level checker for the cartridge bank mapper unit, with its bind to the top level.
// Depends on cbmr_pkg and the macros in cartridge_bank_mapper_rtc_unit_defines.svh.
`include "cartridge_bank_mapper_rtc_unit_defines.svh"

module cbmr_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          access_ready,
	input logic                          result_valid,
	input logic                          result_ready,
	input logic [cbmr_pkg::TARGET_W-1:0]   target,
	input logic [cbmr_pkg::MEM_ADDR_W-1:0] mem_address,
	input logic [cbmr_pkg::DATA_W-1:0]     read_data,
	input logic [cbmr_pkg::DATA_W-1:0]     write_data
);
	import cbmr_pkg::*;

	// A stalled result must hold until its transfer.
	`CBMR_ASSERT_NXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(target) && $stable(mem_address) && $stable(read_data) && $stable(write_data), "result changed while stalled")
	// With the result register empty, the block must take a new access.
	`CBMR_ASSERT_IMP(a_ready_when_empty, !result_valid, access_ready, "access not ready while result empty")
	// RAM addresses never reach above the eight 8K banks.
	`CBMR_ASSERT_IMP(a_ram_addr_range, result_valid && (target == TGT_RAM_RD || target == TGT_RAM_WR), mem_address[21:16] == 6'd0, "RAM address out of range")
	// Data fields are zero unless the target gives them meaning.
	`CBMR_ASSERT_IMP(a_unused_fields_zero, result_valid && target != TGT_DATA && target != TGT_RAM_WR, read_data == 8'd0 && write_data == 8'd0, "unused data field not zero")

endmodule

bind cartridge_bank_mapper_rtc_unit cbmr_checker u_cbmr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.access_ready (access.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.target       (result.target),
	.mem_address  (result.mem_address),
	.read_data    (result.read_data),
	.write_data   (result.write_data)
);

// ===== tb/sv/cbmr_decode_checker.sv =====
// Checker for the cartridge bank mapper: watches the access, result and configuration ports,
// predicts each decoded result from its own copy of the mapper and clock state, and compares.
// Depends on cbmr_pkg and the channel interfaces in cbmr_channels.sv.
module cbmr_decode_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	cbmr_access_if                          acc,
	cbmr_result_if                          res,
	input  logic                            cfg_wr_en,
	input  logic [cbmr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cbmr_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output int                              fail_count,
	output int                              outstanding,
	output int                              results_seen
);
	import cbmr_pkg::*;

	typedef struct packed {
		target_t   target;
		mem_addr_t mem_address;
		byte_t     read_data;
		byte_t     write_data;
	} decoded_t;

	decoded_t expected_decodes[$];
	decoded_t got;
	decoded_t want;

	logic       wide_mode;
	logic       ram_present;
	byte_t      rom_bank;
	logic       ram_enable;
	byte_t      ram_select;
	logic [5:0] seconds;
	logic [5:0] minutes;
	logic [4:0] hours;
	logic [8:0] days;
	logic       halted;
	logic       day_overflow;
	logic       latch_last;
	logic [5:0] lat_seconds;
	logic [5:0] lat_minutes;
	logic [4:0] lat_hours;
	logic [8:0] lat_days;
	logic       lat_halt;
	logic       lat_carry;

	task automatic advance_clock();
		if (seconds != SEC_MIN_LAST) begin
			seconds = seconds + 6'd1;
		end else begin
			seconds = '0;
			if (minutes != SEC_MIN_LAST) begin
				minutes = minutes + 6'd1;
			end else begin
				minutes = '0;
				if (hours != HOUR_LAST) begin
					hours = hours + 5'd1;
				end else begin
					hours = '0;
					days = days + 9'd1;
					if (days == 9'd0) day_overflow = 1'b1;
				end
			end
		end
	endtask

	task automatic decode_access(input opcode_t op, input address_t a, input byte_t d,
		output decoded_t r);
		byte_t lim;
		byte_t v;
		r.target = TGT_NONE;
		r.mem_address = '0;
		r.read_data = '0;
		r.write_data = '0;
		lim = wide_mode ? RAM_LIMIT_WIDE : RAM_LIMIT_NARROW;
		case (op)
			OP_READ: begin
				if (a[15:14] == 2'b00) begin
					r.target = TGT_ROM;
					r.mem_address = mem_addr_t'(a);
				end else if (!a[15]) begin
					r.target = TGT_ROM;
					r.mem_address = {rom_bank, a[13:0]};
				end else if (a[15:13] == RGN_EXT_RAM) begin
					r.target = TGT_DATA;
					r.read_data = OPEN_BYTE;
					if (ram_enable && ram_select <= lim) begin
						if (ram_present) begin
							r.target = TGT_RAM_RD;
							r.read_data = '0;
							r.mem_address = {6'd0, ram_select[2:0], a[12:0]};
						end
					end else if (ram_enable) begin
						case (ram_select)
							SEL_SECONDS: v = {2'b00, lat_seconds};
							SEL_MINUTES: v = {2'b00, lat_minutes};
							SEL_HOURS:   v = {3'b000, lat_hours};
							SEL_DAY_LO:  v = lat_days[7:0];
							SEL_DAY_HI:  v = {lat_carry, lat_halt, 5'b00000, lat_days[8]};
							default:     v = OPEN_BYTE;
						endcase
						r.read_data = v;
					end
				end else begin
					r.target = TGT_DATA;
					r.read_data = d;
				end
			end
			OP_WRITE: begin
				case (a[15:13])
					RGN_RAM_EN: ram_enable = (d[3:0] == RAM_EN_KEY);
					RGN_ROM_BANK: begin
						rom_bank = wide_mode ? d : {1'b0, d[6:0]};
						if (rom_bank == 8'd0) rom_bank = 8'd1;
					end
					RGN_RAM_SEL: ram_select = d;
					RGN_LATCH: begin
						if (!latch_last && d == 8'd1) begin
							lat_seconds = seconds;
							lat_minutes = minutes;
							lat_hours = hours;
							lat_days = days;
							lat_halt = halted;
							lat_carry = day_overflow;
						end
						latch_last = d[0];
					end
					RGN_EXT_RAM: begin
						if (ram_enable && ram_select <= lim) begin
							if (ram_present) begin
								r.target = TGT_RAM_WR;
								r.mem_address = {6'd0, ram_select[2:0], a[12:0]};
								r.write_data = d;
							end
						end else if (ram_enable) begin
							case (ram_select)
								SEL_SECONDS: seconds = (d >= SEC_MIN_LIMIT) ? 6'd0 : d[5:0];
								SEL_MINUTES: minutes = (d >= SEC_MIN_LIMIT) ? 6'd0 : d[5:0];
								SEL_HOURS:   hours = (d >= HOUR_LIMIT) ? 5'd0 : d[4:0];
								SEL_DAY_LO:  days[7:0] = d;
								SEL_DAY_HI: begin
									days[8] = d[0];
									halted = d[6];
									day_overflow = d[7];
								end
								default: ;
							endcase
						end
					end
					default: ;
				endcase
			end
			OP_TICK: begin
				if (!halted) advance_clock();
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wide_mode = 1'b0;
			ram_present = 1'b1;
			rom_bank = 8'd1;
			ram_enable = 1'b0;
			ram_select = '0;
			seconds = '0;
			minutes = '0;
			hours = '0;
			days = '0;
			halted = 1'b0;
			day_overflow = 1'b0;
			latch_last = 1'b0;
			lat_seconds = '0;
			lat_minutes = '0;
			lat_hours = '0;
			lat_days = '0;
			lat_halt = 1'b0;
			lat_carry = 1'b0;
			expected_decodes.delete();
			fail_count = 0;
			outstanding = 0;
			results_seen = 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_WIDE_MODE:   wide_mode = cfg_wdata[0];
					CFG_RAM_PRESENT: ram_present = cfg_wdata[0];
					default: ;
				endcase
			end
			if (res.valid && res.ready) begin
				results_seen++;
				got.target = res.target;
				got.mem_address = res.mem_address;
				got.read_data = res.read_data;
				got.write_data = res.write_data;
				if (expected_decodes.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result transfer: target %0d addr %h rd %h wd %h",
							got.target, got.mem_address, got.read_data, got.write_data);
				end else begin
					want = expected_decodes.pop_front();
					if (got.target !== want.target || got.mem_address !== want.mem_address ||
						got.read_data !== want.read_data ||
						got.write_data !== want.write_data) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("mismatch: expected target %0d addr %h rd %h wd %h",
								want.target, want.mem_address, want.read_data,
								want.write_data);
							$display("          got target %0d addr %h rd %h wd %h",
								got.target, got.mem_address, got.read_data,
								got.write_data);
						end
					end
				end
			end
			if (acc.valid && acc.ready) begin
				decode_access(acc.opcode, acc.address, acc.bus_data, want);
				expected_decodes.push_back(want);
			end
			outstanding = expected_decodes.size();
		end
	end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top for the cartridge bank mapper with real-time clock: clock, reset, directed and
// random bus traffic under several mapper settings, random stalls on the result side, verdict.
// Depends on cbmr_pkg, cbmr_channels.sv, the block itself and cbmr_decode_checker.
module tb;
	import cbmr_pkg::*;

	localparam opcode_t OP_UNUSED   = 2'd3;
	localparam int RANDOM_ITEMS     = 900;
	localparam int PHASE_ITEMS      = 180;
	localparam int QUIET_AFTER      = 780;
	localparam int HOLD_CYCLES      = 150;
	localparam int LIMIT_CYCLES     = 300000;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	int fail_count;
	int outstanding;
	int results_seen;
	int cycle_count = 0;
	int items_sent = 0;
	int ticks_sent = 0;
	int directed_count = 0;
	int phases_run = 0;
	int gap_pct = 0;
	bit quiet = 1'b0;
	bit hold_req = 1'b0;

	cbmr_access_if acc();
	cbmr_result_if res();

	cartridge_bank_mapper_rtc_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.access(acc),
		.result(res),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	cbmr_decode_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.acc(acc),
		.res(res),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.fail_count(fail_count),
		.outstanding(outstanding),
		.results_seen(results_seen)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic address_t rand_addr(input logic [2:0] rgn);
		return {rgn, 13'($urandom)};
	endfunction

	task automatic send(input opcode_t op, input address_t a, input byte_t d);
		if (!quiet && $urandom_range(0, 99) < gap_pct) begin
			acc.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		acc.valid <= 1'b1;
		acc.opcode <= op;
		acc.address <= a;
		acc.bus_data <= d;
		@(posedge clk);
		while (!acc.ready) @(posedge clk);
		items_sent++;
		if (op == OP_TICK) ticks_sent++;
	endtask

	task automatic rtc_write(input byte_t sel, input byte_t val);
		send(OP_WRITE, rand_addr(RGN_RAM_SEL), sel);
		send(OP_WRITE, rand_addr(RGN_EXT_RAM), val);
	endtask

	task automatic enable_ram();
		send(OP_WRITE, rand_addr(RGN_RAM_EN), {4'($urandom), RAM_EN_KEY});
	endtask

	task automatic latch_clock();
		send(OP_WRITE, rand_addr(RGN_LATCH), 8'd0);
		send(OP_WRITE, rand_addr(RGN_LATCH), 8'd1);
	endtask

	task automatic settle();
		acc.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apply_settings(input logic wide, input logic present);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_WIDE_MODE;
		cfg_wdata <= wide;
		@(posedge clk);
		cfg_index <= CFG_RAM_PRESENT;
		cfg_wdata <= present;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		phases_run++;
	endtask

	// Result side: random stall bursts, calm stretches, one long hold-off, none at the end.
	initial begin
		int stall_left;
		int hold_left;
		int calm_left;
		bit calm;
		stall_left = 0;
		hold_left = 0;
		calm_left = 0;
		calm = 1'b0;
		res.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (calm_left == 0) begin
				calm = ($urandom_range(0, 2) == 0);
				calm_left = 64;
			end
			calm_left--;
			if (hold_left > 0) begin
				res.ready <= 1'b0;
				hold_left--;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				res.ready <= 1'b0;
			end else if (stall_left > 0) begin
				res.ready <= 1'b0;
				stall_left--;
			end else if (!quiet && !calm && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 12) - 1;
				res.ready <= 1'b0;
			end else begin
				res.ready <= 1'b1;
			end
		end
	end

	initial begin
		int phase_start;
		int kind;
		int r;
		int n;
		opcode_t op;
		address_t a;
		byte_t d;
		byte_t sel;
		byte_t lim_val;
		logic wide;
		logic present;

		acc.valid <= 1'b0;
		acc.opcode <= OP_READ;
		acc.address <= '0;
		acc.bus_data <= '0;
		cfg_wr_en <= 1'b0;
		cfg_index <= CFG_WIDE_MODE;
		cfg_wdata <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		apply_settings(1'b0, 1'b1);

		send(OP_READ, 16'h0000, 8'h00);
		send(OP_WRITE, 16'h2000, 8'h00);
		send(OP_READ, 16'h4000, 8'h00);
		send(OP_WRITE, 16'h3fff, 8'hff);
		send(OP_READ, 16'h7fff, 8'hff);
		send(OP_READ, 16'ha000, 8'h5a);
		send(OP_WRITE, 16'h1fff, 8'h0a);
		send(OP_WRITE, 16'h5fff, RAM_LIMIT_NARROW);
		send(OP_READ, 16'hbfff, 8'h00);
		send(OP_WRITE, 16'ha000, 8'hff);
		send(OP_UNUSED, 16'hffff, 8'hff);
		send(OP_WRITE, 16'h4000, SEL_SECONDS);
		send(OP_WRITE, 16'ha001, SEC_MIN_LIMIT);
		send(OP_WRITE, 16'ha002, 8'd59);
		rtc_write(SEL_MINUTES, 8'd59);
		rtc_write(SEL_HOURS, 8'd23);
		rtc_write(SEL_DAY_LO, 8'hff);
		rtc_write(SEL_DAY_HI, 8'h01);
		send(OP_TICK, 16'h0000, 8'h00);
		latch_clock();
		send(OP_READ, 16'hb000, 8'h00);
		send(OP_WRITE, 16'ha000, 8'h40);
		send(OP_TICK, 16'hffff, 8'hff);
		latch_clock();
		send(OP_READ, 16'hb000, 8'h00);
		send(OP_READ, 16'h8000, 8'h3c);
		send(OP_WRITE, 16'hc000, 8'h99);
		directed_count = items_sent;

		for (int phase = 0; items_sent - directed_count < RANDOM_ITEMS; phase++) begin
			settle();
			case (phase)
				0: begin wide = 1'b1; present = 1'b1; end
				1: begin wide = 1'b0; present = 1'b0; end
				2: begin wide = 1'b1; present = 1'b0; end
				3: begin wide = 1'b0; present = 1'b1; end
				default: begin wide = 1'($urandom); present = 1'($urandom); end
			endcase
			apply_settings(wide, present);
			if (phase == 0) hold_req = 1'b1;
			phase_start = items_sent;
			while (items_sent - phase_start < PHASE_ITEMS &&
				items_sent - directed_count < RANDOM_ITEMS) begin
				quiet = (items_sent - directed_count > QUIET_AFTER);
				if (phase == 0 && items_sent - phase_start < 40)
					gap_pct = 0;
				else
					gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
				kind = $urandom_range(0, 9);
				case (kind)
					0, 1, 2, 3: begin
						r = $urandom_range(0, 19);
						op = (r < 7) ? OP_READ : (r < 14) ? OP_WRITE :
							(r < 18) ? OP_TICK : OP_UNUSED;
						a = 16'($urandom);
						d = 8'($urandom);
						if (op == OP_WRITE && a[15:13] == RGN_RAM_EN && $urandom_range(0, 1))
							d[3:0] = RAM_EN_KEY;
						send(op, a, d);
					end
					4, 5: begin
						if ($urandom_range(0, 4) == 0)
							send(OP_WRITE, rand_addr(RGN_RAM_EN), 8'($urandom));
						else
							enable_ram();
						sel = $urandom_range(0, 1) ? 8'($urandom_range(0, 8)) : 8'($urandom);
						send(OP_WRITE, rand_addr(RGN_RAM_SEL), sel);
						n = $urandom_range(2, 6);
						repeat (n)
							send($urandom_range(0, 1) ? OP_READ : OP_WRITE,
								rand_addr(RGN_EXT_RAM), 8'($urandom));
					end
					6, 7: begin
						enable_ram();
						sel = SEL_SECONDS + 8'($urandom_range(0, 4));
						lim_val = (sel == SEL_HOURS) ? HOUR_LIMIT : SEC_MIN_LIMIT;
						case ($urandom_range(0, 3))
							0: d = lim_val - 8'd1;
							1: d = lim_val;
							2: d = lim_val + 8'($urandom_range(1, 8));
							default: d = 8'($urandom);
						endcase
						if (sel == SEL_DAY_HI && $urandom_range(0, 2) != 0) d[6] = 1'b0;
						rtc_write(sel, d);
						n = $urandom_range(0, 4);
						repeat (n) send(OP_TICK, 16'($urandom), 8'($urandom));
						if ($urandom_range(0, 3) != 0)
							latch_clock();
						else
							send(OP_WRITE, rand_addr(RGN_LATCH), 8'($urandom_range(0, 3)));
						send(OP_WRITE, rand_addr(RGN_RAM_SEL),
							SEL_SECONDS + 8'($urandom_range(0, 4)));
						send(OP_READ, rand_addr(RGN_EXT_RAM), 8'($urandom));
					end
					8: begin
						case ($urandom_range(0, 2))
							0: d = 8'h00;
							1: d = 8'h80;
							default: d = 8'($urandom);
						endcase
						send(OP_WRITE, rand_addr(RGN_ROM_BANK), d);
						n = $urandom_range(1, 3);
						repeat (n) send(OP_READ, {2'b01, 14'($urandom)}, 8'($urandom));
					end
					default: begin
						enable_ram();
						rtc_write(SEL_SECONDS, 8'd59);
						rtc_write(SEL_MINUTES, 8'd59);
						rtc_write(SEL_HOURS, 8'd23);
						rtc_write(SEL_DAY_LO, 8'hff);
						rtc_write(SEL_DAY_HI, {1'($urandom), 6'd0, 1'($urandom)});
						n = $urandom_range(1, 3);
						repeat (n) send(OP_TICK, 16'($urandom), 8'($urandom));
						latch_clock();
						send(OP_READ, rand_addr(RGN_EXT_RAM), 8'($urandom));
					end
				endcase
			end
		end

		settle();
		repeat (8) @(posedge clk);
		$display("Sent %0d accesses, %0d of them clock ticks, under %0d mapper settings.",
			items_sent, ticks_sent, phases_run);
		$display("Checked %0d decoded results against the prediction.", results_seen);
		if (fail_count == 0 && outstanding == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
